// ----- design/qec_pkg.sv -----
`timescale 1ns / 1ps

package qec_pkg;

    // Count and result widths
    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FREQ_WIDTH  = 48;
    localparam int OUT_CNT_W   = 32;

    // Divider sizing: dividend is |count| scaled by 2^FRAC_BITS, divisor is
    // period * ppr * k with k up to 2.
    localparam int CFG_W   = 16;
    localparam int PROD_W  = 2 * CFG_W;
    localparam int DVS_W   = PROD_W + 1;
    localparam int DIV_W   = COUNT_WIDTH + FRAC_BITS;
    localparam int STEP_W  = $clog2(DIV_W);
    localparam int SAT_W   = ((DIV_W > FREQ_WIDTH) ? DIV_W : FREQ_WIDTH) + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PPR    = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    // Counting modes
    localparam logic [1:0] MODE_TACH = 2'd0;
    localparam logic [1:0] MODE_X1   = 2'd1;
    localparam logic [1:0] MODE_X2   = 2'd2;

    // Item command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // AB state codes used by X2 direction decode
    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_10 = 2'b10;
    localparam logic [1:0] AB_11 = 2'b11;

    typedef struct packed {
        logic take_sample;
        logic take_tick;
        logic load_divisor;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- design/qec_in_if.sv -----
`timescale 1ns / 1ps

interface qec_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic chan_a;
    logic chan_b;

    modport source (output valid, output cmd, output chan_a, output chan_b, input ready);
    modport sink   (input valid, input cmd, input chan_a, input chan_b, output ready);
endinterface

// ----- design/qec_out_if.sv -----
`timescale 1ns / 1ps

interface qec_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pulse_count;
    logic        [1:0]  ab_state;
    logic signed [47:0] freq_q16;
    logic               period_done;

    modport source (output valid, output pulse_count, output ab_state, output freq_q16,
                    output period_done, input ready);
    modport sink   (input valid, input pulse_count, input ab_state, input freq_q16,
                    input period_done, output ready);
endinterface

// ----- design/qec_ctrl.sv -----
`timescale 1ns / 1ps

module qec_ctrl
    import qec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd              = '0;
        o_cmd.take_sample  = accept && (i_in_cmd == CMD_SAMPLE);
        o_cmd.take_tick    = accept && (i_in_cmd == CMD_TICK);
        o_cmd.load_divisor = (r_state == S_MUL);
        o_cmd.div_step     = (r_state == S_DIV);
        o_cmd.finish       = (r_state == S_DONE) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_in_cmd == CMD_TICK)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step  <= STEP_W'(DIV_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // advance one quotient bit per cycle
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/qec_dpath.sv -----
`timescale 1ns / 1ps

module qec_dpath
    import qec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  t_cmd                  i_cmd,
    input  logic                  i_chan_a,
    input  logic                  i_chan_b,
    input  logic                  i_out_ready,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic signed [OUT_CNT_W-1:0]  o_pulse_count,
    output logic [1:0]            o_ab_state,
    output logic signed [FREQ_WIDTH-1:0] o_freq_q16,
    output logic                  o_period_done
);

    // configuration
    logic [1:0]        r_mode;
    logic [CFG_W-1:0]  r_ppr;
    logic [CFG_W-1:0]  r_period;

    // encoder state
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [1:0]             r_prev_ab, n_prev_ab;
    logic                   r_last_a;
    logic                   r_primed;
    logic [FREQ_WIDTH-1:0]  r_freq, n_freq;

    // divider
    logic [DIV_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_divisor;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic              r_out_valid;

    logic [1:0]             ab;
    logic                   edge_hit;
    logic [COUNT_WIDTH-1:0] mag;
    logic [DVS_W:0]         trial;
    logic                   fits;
    logic [SAT_W-1:0]       q_ext;
    logic [SAT_W-1:0]       q_sat;
    logic [63:0]            cnt_ext;

    assign ab = {i_chan_a, i_chan_b};

    assign edge_hit = (r_mode == MODE_X1) ? (!r_last_a && i_chan_a) : (r_last_a != i_chan_a);

    always_comb begin
        n_count   = r_count;
        n_prev_ab = r_prev_ab;
        if (r_primed && edge_hit) begin
            n_prev_ab = ab;
            unique case (r_mode)
                MODE_TACH: n_count = i_chan_b ? r_count + 1'b1 : r_count - 1'b1;
                MODE_X1:   n_count = i_chan_b ? r_count - 1'b1 : r_count + 1'b1;
                MODE_X2: begin
                    if ((r_prev_ab == AB_11 && ab == AB_00) ||
                        (r_prev_ab == AB_00 && ab == AB_11)) begin
                        n_count = r_count + 1'b1;
                    end else if ((r_prev_ab == AB_10 && ab == AB_01) ||
                                 (r_prev_ab == AB_01 && ab == AB_10)) begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: n_count = r_count;
            endcase
        end else if (!r_primed) begin
            n_prev_ab = ab;
        end
    end

    assign mag = r_count[COUNT_WIDTH-1] ? (~r_count + 1'b1) : r_count;

    // restoring divide step
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_divisor});

    // saturate magnitude to the signed result range, then apply sign; zero if the divisor is zero
    always_comb begin
        q_ext = SAT_W'(r_dvd);
        q_sat = q_ext;
        if (r_neg) begin
            if (q_ext > (SAT_W'(1) << (FREQ_WIDTH - 1))) begin
                q_sat = SAT_W'(1) << (FREQ_WIDTH - 1);
            end
            n_freq = FREQ_WIDTH'(~q_sat + 1'b1);
        end else begin
            if (q_ext > ((SAT_W'(1) << (FREQ_WIDTH - 1)) - 1'b1)) begin
                q_sat = (SAT_W'(1) << (FREQ_WIDTH - 1)) - 1'b1;
            end
            n_freq = FREQ_WIDTH'(q_sat);
        end
        if (r_divisor == '0) begin
            n_freq = '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_X1;
            r_ppr       <= CFG_W'(1);
            r_period    <= CFG_W'(1);
            r_count     <= '0;
            r_prev_ab   <= '0;
            r_last_a    <= 1'b0;
            r_primed    <= 1'b0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_PPR:    r_ppr    <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_cmd.take_sample) begin
                r_count   <= n_count;
                r_prev_ab <= n_prev_ab;
                r_last_a  <= i_chan_a;
                r_primed  <= 1'b1;
            end
            if (i_cmd.take_tick) begin
                r_count <= '0;
            end
            if (i_cmd.finish) begin
                r_freq <= n_freq;
            end
            if (i_cmd.take_sample || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_tick) begin
            r_dvd  <= DIV_W'(mag) << FRAC_BITS;
            r_neg  <= r_count[COUNT_WIDTH-1];
            r_rem  <= '0;
            r_prod <= PROD_W'(r_period) * PROD_W'(r_ppr);
        end
        if (i_cmd.load_divisor) begin
            r_divisor <= (r_mode == MODE_X2) ? {r_prod, 1'b0} : {1'b0, r_prod};
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DIV_W-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_divisor}) : DVS_W'(trial);
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            o_pulse_count <= OUT_CNT_W'(64'(signed'(n_count)));
            o_ab_state    <= n_prev_ab;
            o_freq_q16    <= r_freq;
            o_period_done <= 1'b0;
        end else if (i_cmd.finish) begin
            o_pulse_count <= OUT_CNT_W'(cnt_ext);
            o_ab_state    <= r_prev_ab;
            o_freq_q16    <= n_freq;
            o_period_done <= 1'b1;
        end
    end

    assign cnt_ext = 64'(signed'(r_count));

endmodule

// ----- design/quadrature_encoder_counter.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    cmd, chan_a, chan_b
// o_out     out  valid/ready    pulse_count, ab_state, freq_q16, period_done
// i_cfg_*   in   write enable   index (0 mode, 1 pulses_per_rev, 2 sample_period), data
//
// A pin sample's beat appears in the output register on the next edge. A period
// tick forms the divisor, then runs the restoring divider that retires one quotient
// bit per cycle, then loads the result; no input beat is taken meanwhile.
// Reset is synchronous, active low; it clears all counting state and loads
// mode X1, pulses_per_rev 1, sample_period 1. A stalled output holds its beat
// and holds off new input beats until it is taken.

module quadrature_encoder_counter
    import qec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    qec_in_if.sink           i_in,
    qec_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Controller: sequences the multiply, divide steps and result load.
    qec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Datapath: edge decode, pulse count, divider and output register.
    qec_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_chan_a      (i_in.chan_a),
        .i_chan_b      (i_in.chan_b),
        .i_out_ready   (o_out.ready),
        .o_status      (status),
        .o_out_valid   (o_out.valid),
        .o_pulse_count (o_out.pulse_count),
        .o_ab_state    (o_out.ab_state),
        .o_freq_q16    (o_out.freq_q16),
        .o_period_done (o_out.period_done)
    );

endmodule
